// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl, clk and rst come from the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sst assertion failed");

// next-cycle implication
`define SST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

  localparam int MAX_MIPS_DEF   = 16;
  localparam int MAX_LAYERS_DEF = 64;

  localparam int REQ_W   = 2;
  localparam int MIP_W   = 4;
  localparam int MCNT_W  = 5;
  localparam int LAYER_W = 6;
  localparam int LCNT_W  = 7;
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 7;
  localparam int TOTAL_W = MCNT_W + LCNT_W;

  localparam logic [REQ_W-1:0] REQ_SET_WHOLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_RANGE = 2'd1;

  localparam logic CFG_MIP_LEVELS   = 1'b0;
  localparam logic CFG_ARRAY_LAYERS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FILL,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_READ
  } state_t;

  // effective image geometry after clamping
  typedef struct packed {
    logic [MCNT_W-1:0]  mips;
    logic [LCNT_W-1:0]  layers;
    logic [TOTAL_W-1:0] total;
  } geom_t;

endpackage

// ===== rtl/core/sst_mem.sv =====
module sst_mem #(
  parameter int DEPTH  = sst_pkg::MAX_MIPS_DEF * sst_pkg::MAX_LAYERS_DEF,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [sst_pkg::CODE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [sst_pkg::CODE_W-1:0] rd_data
);

  logic [sst_pkg::CODE_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cells[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sst_seq.sv =====
`include "assert_macros.svh"

module sst_seq #(
  parameter int ADDR_W = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sst_pkg::REQ_W-1:0]   req_type,
  input  logic [sst_pkg::MIP_W-1:0]   base_mip,
  input  logic [sst_pkg::MCNT_W-1:0]  mip_count,
  input  logic [sst_pkg::LAYER_W-1:0] base_layer,
  input  logic [sst_pkg::LCNT_W-1:0]  layer_count,
  input  logic [sst_pkg::CODE_W-1:0]  new_code,
  input  logic                        cfg_we,
  input  sst_pkg::geom_t              geom,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [sst_pkg::CODE_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [sst_pkg::CODE_W-1:0]  rd_data,
  output logic                        busy,
  output logic                        done,
  output logic [sst_pkg::CODE_W-1:0]  code_out,
  output logic                        split_mode,
  output logic                        range_error
);

  localparam int TOTAL_W = sst_pkg::TOTAL_W;

  sst_pkg::state_t state, state_next;

  logic                         per_cell, per_cell_next;
  logic [sst_pkg::CODE_W-1:0]   whole_code, whole_code_next;
  logic [sst_pkg::CODE_W-1:0]   cell0;
  logic [sst_pkg::CODE_W-1:0]   code_q, code_q_next;
  logic [sst_pkg::LCNT_W-1:0]   lc_q, lc_q_next;
  logic [sst_pkg::LCNT_W-1:0]   l_idx, l_idx_next;
  logic [sst_pkg::MCNT_W-1:0]   rows_left, rows_left_next;
  logic [sst_pkg::TOTAL_W-1:0]  row_start, row_start_next;
  logic [sst_pkg::TOTAL_W-1:0]  wr_ptr, wr_ptr_next;
  logic [sst_pkg::TOTAL_W-1:0]  idx, idx_next;
  logic                         differ, differ_next;
  logic                         rd_pend;
  logic                         done_next;
  logic [sst_pkg::CODE_W-1:0]   code_out_next;
  logic                         split_next;
  logic                         err_next;

  logic                         range_bad;
  logic                         read_bad;
  logic                         mismatch;
  logic                         read_req;
  logic [sst_pkg::TOTAL_W-1:0]  base_addr;
  logic [sst_pkg::TOTAL_W-1:0]  next_row;

  assign busy = (state != sst_pkg::ST_IDLE);

  assign range_bad = (mip_count == '0) || (layer_count == '0) ||
                     ((6'(base_mip) + 6'(mip_count)) > 6'(geom.mips)) ||
                     ((8'(base_layer) + 8'(layer_count)) > 8'(geom.layers));
  assign read_bad  = (5'(base_mip) >= geom.mips) || (7'(base_layer) >= geom.layers);
  assign base_addr = TOTAL_W'(base_mip) * TOTAL_W'(geom.layers) + TOTAL_W'(base_layer);
  assign next_row  = row_start + sst_pkg::TOTAL_W'(geom.layers);
  assign read_req  = (req_type != sst_pkg::REQ_SET_WHOLE) && (req_type != sst_pkg::REQ_SET_RANGE);
  assign mismatch  = rd_pend && (rd_data != cell0);

  // memory port control
  always_comb begin
    wr_en   = (state == sst_pkg::ST_EXPAND) || (state == sst_pkg::ST_FILL);
    wr_addr = (state == sst_pkg::ST_EXPAND) ? ADDR_W'(idx) : ADDR_W'(wr_ptr);
    wr_data = (state == sst_pkg::ST_EXPAND) ? whole_code : code_q;
    rd_en   = (state == sst_pkg::ST_SCAN) ||
              ((state == sst_pkg::ST_IDLE) && start && read_req && !read_bad && per_cell);
    rd_addr = (state == sst_pkg::ST_SCAN) ? ADDR_W'(idx) : ADDR_W'(base_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    per_cell_next   = per_cell;
    whole_code_next = whole_code;
    code_q_next     = code_q;
    lc_q_next       = lc_q;
    l_idx_next      = l_idx;
    rows_left_next  = rows_left;
    row_start_next  = row_start;
    wr_ptr_next     = wr_ptr;
    idx_next        = idx;
    differ_next     = differ || mismatch;
    done_next       = 1'b0;
    code_out_next   = code_out;
    split_next      = split_mode;
    err_next        = range_error;

    // a geometry change drops back to compact mode with the code of cell 0
    if (cfg_we && per_cell) begin
      whole_code_next = cell0;
      per_cell_next   = 1'b0;
    end

    unique case (state)
      sst_pkg::ST_IDLE: begin
        if (start) begin
          code_q_next    = new_code;
          lc_q_next      = layer_count;
          rows_left_next = mip_count;
          row_start_next = base_addr;
          wr_ptr_next    = base_addr;
          l_idx_next     = '0;
          idx_next       = '0;
          differ_next    = 1'b0;
          case (req_type)
            sst_pkg::REQ_SET_WHOLE: begin
              whole_code_next = new_code;
              per_cell_next   = 1'b0;
              done_next       = 1'b1;
              code_out_next   = new_code;
              split_next      = 1'b0;
              err_next        = 1'b0;
            end
            sst_pkg::REQ_SET_RANGE: begin
              if (range_bad) begin
                done_next     = 1'b1;
                code_out_next = '0;
                split_next    = per_cell;
                err_next      = 1'b1;
              end else if (!per_cell && (geom.total == TOTAL_W'(1))) begin
                whole_code_next = new_code;
                done_next       = 1'b1;
                code_out_next   = new_code;
                split_next      = 1'b0;
                err_next        = 1'b0;
              end else if (!per_cell) begin
                state_next = sst_pkg::ST_EXPAND;
              end else begin
                state_next = sst_pkg::ST_FILL;
              end
            end
            default: begin
              if (read_bad) begin
                done_next     = 1'b1;
                code_out_next = '0;
                split_next    = per_cell;
                err_next      = 1'b1;
              end else if (!per_cell) begin
                done_next     = 1'b1;
                code_out_next = whole_code;
                split_next    = 1'b0;
                err_next      = 1'b0;
              end else begin
                state_next = sst_pkg::ST_READ;
              end
            end
          endcase
        end
      end
      sst_pkg::ST_EXPAND: begin
        idx_next = idx + TOTAL_W'(1);
        if (idx >= geom.total - TOTAL_W'(1)) begin
          per_cell_next = 1'b1;
          state_next    = sst_pkg::ST_FILL;
        end
      end
      sst_pkg::ST_FILL: begin
        if (l_idx == lc_q - sst_pkg::LCNT_W'(1)) begin
          l_idx_next     = '0;
          row_start_next = next_row;
          wr_ptr_next    = next_row;
          rows_left_next = rows_left - sst_pkg::MCNT_W'(1);
          if (rows_left == sst_pkg::MCNT_W'(1)) begin
            idx_next   = TOTAL_W'(1);
            state_next = sst_pkg::ST_SCAN;
          end
        end else begin
          l_idx_next  = l_idx + sst_pkg::LCNT_W'(1);
          wr_ptr_next = wr_ptr + TOTAL_W'(1);
        end
      end
      sst_pkg::ST_SCAN: begin
        idx_next = idx + TOTAL_W'(1);
        if (idx >= geom.total - TOTAL_W'(1)) begin
          state_next = sst_pkg::ST_SCAN_TAIL;
        end
      end
      sst_pkg::ST_SCAN_TAIL: begin
        // base cell lies inside the rectangle, so it always reads back the new code
        state_next    = sst_pkg::ST_IDLE;
        done_next     = 1'b1;
        code_out_next = code_q;
        err_next      = 1'b0;
        if (differ || mismatch) begin
          split_next = 1'b1;
        end else begin
          whole_code_next = cell0;
          per_cell_next   = 1'b0;
          split_next      = 1'b0;
        end
      end
      sst_pkg::ST_READ: begin
        state_next    = sst_pkg::ST_IDLE;
        done_next     = 1'b1;
        code_out_next = rd_data;
        split_next    = 1'b1;
        err_next      = 1'b0;
      end
      default: begin
        state_next = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      per_cell    <= 1'b0;
      whole_code  <= '0;
      done        <= 1'b0;
      rd_pend     <= 1'b0;
      differ      <= 1'b0;
      split_mode  <= 1'b0;
      range_error <= 1'b0;
    end else begin
      per_cell    <= per_cell_next;
      whole_code  <= whole_code_next;
      done        <= done_next;
      rd_pend     <= (state == sst_pkg::ST_SCAN);
      differ      <= differ_next;
      split_mode  <= split_next;
      range_error <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    code_q    <= code_q_next;
    lc_q      <= lc_q_next;
    l_idx     <= l_idx_next;
    rows_left <= rows_left_next;
    row_start <= row_start_next;
    wr_ptr    <= wr_ptr_next;
    idx       <= idx_next;
    code_out  <= code_out_next;
    // shadow of cell 0 so a config write can collapse without a memory read
    if (wr_en && (wr_addr == '0)) begin
      cell0 <= wr_data;
    end
  end

  `SST_ASSERT_IMP(a_no_port_overlap, wr_en, !rd_en)
  `SST_ASSERT_IMP(a_done_mode_match, done, split_mode == per_cell)
  `SST_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `SST_ASSERT_NXT(a_read_one_wait, state == sst_pkg::ST_READ, done && !busy)
  `SST_ASSERT_IMP(a_error_zero_code, done && range_error, code_out == '0)

endmodule

// ===== rtl/core/subresource_state_tracker.sv =====
// Tracks an 8-bit state code per (mip, layer) cell of one image. Pulse start while busy is
// low to issue one transaction; its result appears on code_out, split_mode and range_error
// for exactly one cycle with done high, and the receiver cannot stall it. Whole-image
// writes, rejected ranges or reads, single-cell images and reads in compact mode raise done
// in the cycle after start; a read in per-cell mode first passes through ST_READ for the cell
// memory's registered read. A range write runs one memory access per cycle: an expand pass
// over all mips*layers cells (only when leaving compact mode), a fill of each cell of the
// rectangle, a uniformity scan of the other cells against cell 0, and a final tail step.
// The cell memory needs no clearing pass after reset. Config writes need no handshake.
module subresource_state_tracker #(
  parameter int MAX_MIPS   = sst_pkg::MAX_MIPS_DEF,
  parameter int MAX_LAYERS = sst_pkg::MAX_LAYERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sst_pkg::REQ_W-1:0]   req_type,
  input  logic [sst_pkg::MIP_W-1:0]   base_mip,
  input  logic [sst_pkg::MCNT_W-1:0]  mip_count,
  input  logic [sst_pkg::LAYER_W-1:0] base_layer,
  input  logic [sst_pkg::LCNT_W-1:0]  layer_count,
  input  logic [sst_pkg::CODE_W-1:0]  new_code,
  output logic                        done,
  output logic [sst_pkg::CODE_W-1:0]  code_out,
  output logic                        split_mode,
  output logic                        range_error,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]   cfg_data
);

  localparam int DEPTH  = MAX_MIPS * MAX_LAYERS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sst_pkg::geom_t geom, geom_next;

  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [sst_pkg::CODE_W-1:0] wr_data;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [sst_pkg::CODE_W-1:0] rd_data;

  logic [sst_pkg::MCNT_W-1:0] mips_clamp;
  logic [sst_pkg::LCNT_W-1:0] layers_clamp;

  // zero acts as one, values past the table act as its size
  always_comb begin
    if (cfg_data[sst_pkg::MCNT_W-1:0] == '0) begin
      mips_clamp = sst_pkg::MCNT_W'(1);
    end else if (int'(cfg_data[sst_pkg::MCNT_W-1:0]) > MAX_MIPS) begin
      mips_clamp = sst_pkg::MCNT_W'(MAX_MIPS);
    end else begin
      mips_clamp = cfg_data[sst_pkg::MCNT_W-1:0];
    end
    if (cfg_data == '0) begin
      layers_clamp = sst_pkg::LCNT_W'(1);
    end else if (int'(cfg_data) > MAX_LAYERS) begin
      layers_clamp = sst_pkg::LCNT_W'(MAX_LAYERS);
    end else begin
      layers_clamp = cfg_data;
    end
  end

  always_comb begin
    geom_next = geom;
    if (cfg_we) begin
      unique case (cfg_index)
        sst_pkg::CFG_MIP_LEVELS:   geom_next.mips   = mips_clamp;
        sst_pkg::CFG_ARRAY_LAYERS: geom_next.layers = layers_clamp;
        default:                   geom_next        = geom;
      endcase
      geom_next.total = sst_pkg::TOTAL_W'(geom_next.mips) * sst_pkg::TOTAL_W'(geom_next.layers);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.mips   <= sst_pkg::MCNT_W'(1);
      geom.layers <= sst_pkg::LCNT_W'(1);
      geom.total  <= sst_pkg::TOTAL_W'(1);
    end else begin
      geom <= geom_next;
    end
  end

  sst_seq #(
    .ADDR_W(ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .base_mip   (base_mip),
    .mip_count  (mip_count),
    .base_layer (base_layer),
    .layer_count(layer_count),
    .new_code   (new_code),
    .cfg_we     (cfg_we),
    .geom       (geom),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .done       (done),
    .code_out   (code_out),
    .split_mode (split_mode),
    .range_error(range_error)
  );

  sst_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
